/* rtl/icmp_echo_responder_macros.svh */
// Assertion helpers shared by the RTL files.
// Each expects clk and rst in scope and checks only outside reset.
`ifndef ICMP_ECHO_RESPONDER_MACROS_SVH
`define ICMP_ECHO_RESPONDER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ICMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define ICMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/icmp_pkg.sv */
`timescale 1ns / 1ps
package icmp_pkg;

  // word count field of a job, wide enough for the largest buffer
  localparam int CNT_W = 7;
  localparam int LEN_W = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;

  // keeps code, identifier, sequence; clears type and checksum
  localparam logic [63:0] REPLY_CLEAR_MASK = 64'h00FF_0000_FFFF_FFFF;
  localparam logic [7:0]  TYPE_ECHO_REQ    = 8'd8;
  localparam logic [15:0] CKSUM_GOOD       = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CKSUM    = 3'd2,
    ST_NOT_ECHO = 3'd3,
    ST_LARGE    = 3'd4
  } status_t;

  // one classified message handed from front to back
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] word_count;
    logic [3:0]       last_bytes;
    logic [15:0]      cksum;
    logic [31:0]      peer;
  } job_t;

  // ones on the first n bytes, counted from the most significant byte
  function automatic logic [63:0] lead_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[63-8*i -: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // ones-complement add of the four 16-bit halves of w into acc
  function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [63:0] w);
    logic [18:0] s;
    logic [16:0] f;
    s = 19'(acc) + 19'(w[63:48]) + 19'(w[47:32]) + 19'(w[31:16]) + 19'(w[15:0]);
    f = 17'(s[15:0]) + 17'(s[18:16]);
    return f[15:0] + 16'(f[16]);
  endfunction

endpackage

/* rtl/icmp_job_q.sv */
`timescale 1ns / 1ps
module icmp_job_q (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  icmp_pkg::job_t din,
  input  logic          pop,
  output icmp_pkg::job_t dout,
  output logic          empty,
  output logic          full
);
  import icmp_pkg::*;

  job_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign dout  = slot[rp];
  assign empty = (cnt == 2'd0);
  assign full  = (cnt == 2'd2);

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wp] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      priority if ((push && !full) && !(pop && !empty)) begin
        cnt <= cnt + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt <= cnt - 2'd1;
      end else begin
        cnt <= cnt;
      end
    end
  end

endmodule

/* rtl/icmp_front.sv */
`timescale 1ns / 1ps
`include "icmp_echo_responder_macros.svh"
module icmp_front #(
  parameter  int BUFFER_WORDS = 64,
  localparam int AW = $clog2(BUFFER_WORDS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  logic [63:0]    msg_word,
  input  logic [3:0]     bytes_valid,
  input  logic           last_word,
  input  logic [31:0]    peer_addr,
  input  logic           q_full,
  output logic           push,
  output icmp_pkg::job_t job,
  output logic           finishing,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [63:0]    wr_data
);
  import icmp_pkg::*;

  localparam int CW = $clog2(BUFFER_WORDS + 1);

  logic [CW-1:0]    word_count;
  logic [LEN_W-1:0] byte_length;
  logic [15:0]      verify_sum;
  logic [15:0]      reply_sum;
  logic [31:0]      saved_peer;
  logic             overflow_seen;
  logic [7:0]       first_type;

  logic             accept;
  logic [3:0]       n;
  logic             has_bytes;
  logic             room;
  logic [63:0]      wm;
  logic [LEN_W:0]   len_sum;
  logic [LEN_W-1:0] byte_length_next;
  status_t          status_next;

  assign accept = start && !busy;

  // byte count of this beat: full unless last, capped at eight
  always_comb begin
    priority if (!last_word) begin
      n = 4'd8;
    end else if (bytes_valid > 4'd8) begin
      n = 4'd8;
    end else begin
      n = bytes_valid;
    end
  end

  assign has_bytes = (n != 4'd0);
  assign room      = (word_count < CW'(BUFFER_WORDS));
  assign wm        = msg_word & lead_mask(n);
  assign len_sum   = (LEN_W+1)'(byte_length) + (LEN_W+1)'(n);
  assign byte_length_next = (len_sum > (LEN_W+1)'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];

  // store write port
  assign wr_en   = accept && has_bytes && room;
  assign wr_addr = word_count[AW-1:0];
  assign wr_data = wm;

  // per-message accumulation, cleared after the closing cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      byte_length   <= '0;
      verify_sum    <= '0;
      reply_sum     <= '0;
      saved_peer    <= '0;
      overflow_seen <= 1'b0;
      first_type    <= '0;
      finishing     <= 1'b0;
    end else if (accept) begin
      if (word_count == '0) begin
        saved_peer <= peer_addr;
      end
      if (has_bytes) begin
        verify_sum  <= oc_add(verify_sum, wm);
        reply_sum   <= oc_add(reply_sum, (byte_length == '0) ? (wm & REPLY_CLEAR_MASK) : wm);
        byte_length <= byte_length_next;
        if (word_count == '0) begin
          first_type <= wm[63:56];
        end
        if (room) begin
          word_count <= word_count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      finishing <= last_word;
    end else if (finishing) begin
      word_count    <= '0;
      byte_length   <= '0;
      verify_sum    <= '0;
      reply_sum     <= '0;
      overflow_seen <= 1'b0;
      finishing     <= 1'b0;
    end
  end

  // message checks in priority order
  always_comb begin
    priority if (byte_length < LEN_W'(8)) begin
      status_next = ST_SHORT;
    end else if (verify_sum != CKSUM_GOOD) begin
      status_next = ST_CKSUM;
    end else if ((word_count == '0) || (first_type != TYPE_ECHO_REQ)) begin
      status_next = ST_NOT_ECHO;
    end else if (overflow_seen) begin
      status_next = ST_LARGE;
    end else begin
      status_next = ST_OK;
    end
  end

  // job handed to the queue in the closing cycle
  assign push            = finishing;
  assign job.status      = status_next;
  assign job.word_count  = CNT_W'(word_count);
  assign job.last_bytes  = (byte_length[2:0] == 3'd0) ? 4'd8 : {1'b0, byte_length[2:0]};
  assign job.cksum       = ~reply_sum;
  assign job.peer        = saved_peer;

  `ICMP_ASSERT_SAME(a_push_room, push, !q_full, "job pushed into a full queue")
  `ICMP_ASSERT_NEXT(a_last_closes, accept && last_word, finishing, "last beat did not close")
  `ICMP_ASSERT_SAME(a_no_accept_closing, finishing, !accept, "beat taken while closing")

endmodule

/* rtl/icmp_back.sv */
`timescale 1ns / 1ps
`include "icmp_echo_responder_macros.svh"
module icmp_back #(
  parameter  int BUFFER_WORDS = 64,
  localparam int AW = $clog2(BUFFER_WORDS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [63:0]    wr_data,
  input  logic           q_empty,
  input  icmp_pkg::job_t job_in,
  output logic           pop,
  output logic           active,
  output logic           reply_valid,
  output logic [63:0]    reply_word,
  output logic [3:0]     reply_bytes,
  output logic           reply_last,
  output logic [2:0]     status,
  output logic [31:0]    reply_dst_addr
);
  import icmp_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  logic [63:0] mem [BUFFER_WORDS];

  bk_state_t   state;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] last_idx;
  logic [15:0] job_cksum;
  logic [3:0]  job_last_bytes;
  logic [31:0] job_peer;

  logic [63:0] rd_data;
  logic        pend_v;
  logic        pend_first;
  logic        pend_last;

  logic        out_v;
  logic [63:0] out_word;
  logic [3:0]  out_bytes;
  logic        out_last;
  status_t     out_status;
  logic [31:0] out_dst;

  logic        job_ok;

  assign job_ok = (job_in.status == ST_OK);
  assign pop    = (state == BK_IDLE) && !pend_v && !q_empty;
  assign active = (state == BK_RUN) || pend_v;

  // message store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_RUN) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // job fields held while the reply streams out
  always_ff @(posedge clk) begin
    if (pop) begin
      last_idx       <= AW'(job_in.word_count - CNT_W'(1));
      job_cksum      <= job_in.cksum;
      job_last_bytes <= job_in.last_bytes;
      job_peer       <= job_in.peer;
    end
  end

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      rd_ptr     <= '0;
      pend_v     <= 1'b0;
      pend_first <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          pend_v <= 1'b0;
          if (pop && job_ok) begin
            state  <= BK_RUN;
            rd_ptr <= '0;
          end
        end
        BK_RUN: begin
          pend_v     <= 1'b1;
          pend_first <= (rd_ptr == '0);
          pend_last  <= (rd_ptr == last_idx);
          if (rd_ptr == last_idx) begin
            state <= BK_IDLE;
          end else begin
            rd_ptr <= rd_ptr + AW'(1);
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  // result register: reply beats or a single drop beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= pend_v || (pop && !job_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (pend_v) begin
      out_word   <= pend_first ? ((rd_data & REPLY_CLEAR_MASK) | {16'h0000, job_cksum, 32'h0})
                               : rd_data;
      out_bytes  <= pend_last ? job_last_bytes : 4'd8;
      out_last   <= pend_last;
      out_status <= ST_OK;
      out_dst    <= job_peer;
    end else if (pop && !job_ok) begin
      out_word   <= '0;
      out_bytes  <= 4'd0;
      out_last   <= 1'b1;
      out_status <= job_in.status;
      out_dst    <= job_in.peer;
    end
  end

  assign reply_valid    = out_v;
  assign reply_word     = out_word;
  assign reply_bytes    = out_bytes;
  assign reply_last     = out_last;
  assign status         = out_status;
  assign reply_dst_addr = out_dst;

  `ICMP_ASSERT_SAME(a_ok_bytes, out_v && (out_status == ST_OK), out_bytes != 4'd0, "empty reply beat")
  `ICMP_ASSERT_NEXT(a_pop_run, pop && job_ok, state == BK_RUN, "good job did not start reading")
  `ICMP_ASSERT_SAME(a_ptr_range, state == BK_RUN, rd_ptr <= last_idx, "read pointer past message")

endmodule

/* rtl/icmp_echo_responder.sv */
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// config    local_addr_we          local_addr_wdata
// message   start / busy           msg_word, bytes_valid, last_word, peer_addr
// result    reply_valid (strobe)   reply_word, reply_bytes, reply_last, status,
//                                  reply_src_addr, reply_dst_addr
//
// Beats are taken one per cycle while busy is low; after the last beat busy stays high
// until the final result of that message is on the ports. Checks run in the closing
// cycle and the job passes through the job queue; a drop result is registered from the
// popped job, reply beats go through the read state, store read and pending stage, then
// one reply beat per cycle. A message is loaded, then read back, one after another.
// rst is synchronous and active high; local_addr resets to zero; results cannot be stalled.
module icmp_echo_responder #(
  parameter int BUFFER_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        local_addr_we,
  input  logic [31:0] local_addr_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] msg_word,
  input  logic [3:0]  bytes_valid,
  input  logic        last_word,
  input  logic [31:0] peer_addr,
  output logic        reply_valid,
  output logic [63:0] reply_word,
  output logic [3:0]  reply_bytes,
  output logic        reply_last,
  output logic [2:0]  status,
  output logic [31:0] reply_src_addr,
  output logic [31:0] reply_dst_addr
);
  import icmp_pkg::*;

  localparam int AW = $clog2(BUFFER_WORDS);

  logic [31:0]   local_addr;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  logic          finishing;
  logic          back_active;
  job_t          job_push;
  job_t          job_pop;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
    end else if (local_addr_we) begin
      local_addr <= local_addr_wdata;
    end
  end

  assign reply_src_addr = local_addr;
  assign busy = finishing || !q_empty || back_active;

  icmp_front #(
    .BUFFER_WORDS(BUFFER_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .msg_word   (msg_word),
    .bytes_valid(bytes_valid),
    .last_word  (last_word),
    .peer_addr  (peer_addr),
    .q_full     (q_full),
    .push       (push),
    .job        (job_push),
    .finishing  (finishing),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  icmp_job_q u_job_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_push),
    .pop  (pop),
    .dout (job_pop),
    .empty(q_empty),
    .full (q_full)
  );

  icmp_back #(
    .BUFFER_WORDS(BUFFER_WORDS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .q_empty       (q_empty),
    .job_in        (job_pop),
    .pop           (pop),
    .active        (back_active),
    .reply_valid   (reply_valid),
    .reply_word    (reply_word),
    .reply_bytes   (reply_bytes),
    .reply_last    (reply_last),
    .status        (status),
    .reply_dst_addr(reply_dst_addr)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import icmp_pkg::*;

  localparam int BUF_WORDS  = 64;
  localparam int RAND_BEATS = 200;
  localparam int DRAIN_CYC  = 10;

  // payload fill patterns for generated messages
  localparam logic [1:0] FILL_RAND = 2'd0;
  localparam logic [1:0] FILL_ONES = 2'd1;
  localparam logic [1:0] FILL_ZERO = 2'd2;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbv;
    logic        fin;
    logic [31:0] peer;
  } beat_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        fin;
    status_t     st;
    logic [31:0] src;
    logic [31:0] dst;
  } reply_t;

  // one directed message; typed rows carry their drop status directly
  typedef struct packed {
    logic [10:0] len;
    logic [7:0]  typ;
    logic [7:0]  code;
    logic [31:0] idseq;
    logic [1:0]  fill;
    logic        bad_ck;
    logic        wide_bv;
    logic        empty_tail;
    logic        typed;
    status_t     st;
  } dir_row_t;

  logic        clk;
  logic        rst              = 1'b1;
  logic        local_addr_we    = 1'b0;
  logic [31:0] local_addr_wdata = '0;
  logic        start            = 1'b0;
  logic        busy;
  logic [63:0] msg_word         = '0;
  logic [3:0]  bytes_valid      = '0;
  logic        last_word        = 1'b0;
  logic [31:0] peer_addr        = '0;
  logic        reply_valid;
  logic [63:0] reply_word;
  logic [3:0]  reply_bytes;
  logic        reply_last;
  logic [2:0]  status;
  logic [31:0] reply_src_addr;
  logic [31:0] reply_dst_addr;

  icmp_echo_responder #(.BUFFER_WORDS(BUF_WORDS)) u_dut (
    .clk             (clk),
    .rst             (rst),
    .local_addr_we   (local_addr_we),
    .local_addr_wdata(local_addr_wdata),
    .start           (start),
    .busy            (busy),
    .msg_word        (msg_word),
    .bytes_valid     (bytes_valid),
    .last_word       (last_word),
    .peer_addr       (peer_addr),
    .reply_valid     (reply_valid),
    .reply_word      (reply_word),
    .reply_bytes     (reply_bytes),
    .reply_last      (reply_last),
    .status          (status),
    .reply_src_addr  (reply_src_addr),
    .reply_dst_addr  (reply_dst_addr)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL icmp_echo_responder");
    $finish;
  end

  // responder image kept by the testbench
  logic [63:0] img_mem [0:BUF_WORDS-1];
  int          n_words    = 0;
  int          n_bytes    = 0;
  logic [15:0] sum_rx     = '0;
  logic [15:0] sum_tx     = '0;
  logic [31:0] peer_hold  = '0;
  logic [31:0] addr_cfg   = '0;
  bit          overflowed = 1'b0;

  reply_t reply_q[$];
  reply_t msg_replies[$];
  beat_t  msg_beats[$];
  int     beats_sent = 0;
  int     mismatches = 0;

  // directed messages
  dir_row_t dir_tab [13] = '{
    '{11'd8,  8'd8,   8'h00, 32'h1234_0001, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{11'd0,  8'd8,   8'h00, 32'h0000_0000, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b1, ST_SHORT},
    '{11'd4,  8'd8,   8'h00, 32'h0000_0000, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b1, ST_SHORT},
    '{11'd7,  8'd8,   8'h00, 32'hFFFF_FFFF, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b1, ST_SHORT},
    '{11'd16, 8'd8,   8'h00, 32'h0042_0007, FILL_RAND, 1'b1, 1'b0, 1'b0, 1'b1, ST_CKSUM},
    '{11'd8,  8'd0,   8'h00, 32'h0001_0001, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b1, ST_NOT_ECHO},
    '{11'd12, 8'hFF,  8'hFF, 32'h0001_0002, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b1, ST_NOT_ECHO},
    '{11'd13, 8'd8,   8'h00, 32'h0002_0003, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{11'd24, 8'd8,   8'h00, 32'h0003_0004, FILL_RAND, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK},
    '{11'd16, 8'd8,   8'h00, 32'h0004_0005, FILL_RAND, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK},
    '{11'd24, 8'd8,   8'hFF, 32'hFFFF_FFFF, FILL_ONES, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{11'd16, 8'd8,   8'h00, 32'h0000_0000, FILL_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{11'd1,  8'd8,   8'h00, 32'h0000_0000, FILL_RAND, 1'b0, 1'b0, 1'b0, 1'b1, ST_SHORT}
  };

  // ones on the first n bytes, counted from the top byte
  function automatic logic [63:0] keep_bytes(input int n);
    if (n <= 0) return 64'h0;
    if (n >= 8) return '1;
    return ~64'h0 << (64 - 8 * n);
  endfunction

  // end-around-carry sum of the four halves of w into acc
  function automatic logic [15:0] oc_add16(input logic [15:0] acc, input logic [63:0] w);
    int unsigned t;
    t = 32'(acc);
    for (int k = 0; k < 4; k++) t += 32'(w[16*k +: 16]);
    while ((t >> 16) != 0) t = (t & 32'hFFFF) + (t >> 16);
    return t[15:0];
  endfunction

  // advance the image by one accepted beat; fills msg_replies
  task automatic predict_reply(input beat_t b);
    int          nb;
    int          rest;
    logic [63:0] w;
    logic [7:0]  first_type;
    status_t     st;
    reply_t      r;
    msg_replies.delete();
    if (n_words == 0) peer_hold = b.peer;
    nb = b.fin ? ((b.nbv > 8) ? 8 : int'(b.nbv)) : 8;
    if (nb > 0) begin
      w = b.word & keep_bytes(nb);
      sum_rx = oc_add16(sum_rx, w);
      sum_tx = oc_add16(sum_tx, (n_bytes == 0) ? (w & REPLY_CLEAR_MASK) : w);
      if (n_words < BUF_WORDS) begin
        img_mem[n_words] = w;
        n_words++;
      end else begin
        overflowed = 1'b1;
      end
      n_bytes = (n_bytes + nb > 1023) ? 1023 : n_bytes + nb;
    end
    if (!b.fin) return;

    // classify in priority order
    first_type = (n_words > 0) ? img_mem[0][63:56] : 8'h00;
    if (n_bytes < 8) st = ST_SHORT;
    else if (sum_rx != CKSUM_GOOD) st = ST_CKSUM;
    else if (first_type != TYPE_ECHO_REQ) st = ST_NOT_ECHO;
    else if (overflowed) st = ST_LARGE;
    else st = ST_OK;

    if (st != ST_OK) begin
      r = '{64'h0, 4'h0, 1'b1, st, addr_cfg, peer_hold};
      msg_replies.push_back(r);
    end else begin
      rest = n_bytes;
      for (int i = 0; i < n_words; i++) begin
        nb = (rest > 8) ? 8 : rest;
        w = img_mem[i];
        if (i == 0) w = (w & REPLY_CLEAR_MASK) | {16'h0000, ~sum_tx, 32'h0000_0000};
        w &= keep_bytes(nb);
        r = '{w, 4'(nb), (i == n_words - 1), ST_OK, addr_cfg, peer_hold};
        msg_replies.push_back(r);
        rest -= nb;
      end
    end
    n_words    = 0;
    n_bytes    = 0;
    sum_rx     = '0;
    sum_tx     = '0;
    overflowed = 1'b0;
  endtask

  // build the beats of one message with its checksum fixed up
  task automatic build_msg(input int len, input logic [7:0] typ, input logic [7:0] code,
                           input logic [31:0] idseq, input logic [1:0] fill,
                           input bit bad_ck, input bit wide_bv, input bit empty_tail);
    logic [63:0] words [0:139];
    logic [15:0] acc;
    int          nw;
    int          nb;
    beat_t       b;
    nw = (len + 7) / 8;
    msg_beats.delete();
    for (int i = 0; i < nw; i++) begin
      if (i == 0) words[i] = {typ, code, 16'h0000, idseq};
      else if (fill == FILL_ONES) words[i] = '1;
      else if (fill == FILL_ZERO) words[i] = '0;
      else words[i] = {$urandom, $urandom};
      nb = (i == nw - 1) ? len - 8 * i : 8;
      words[i] &= keep_bytes(nb);
    end
    // checksum field brings the whole sum to all ones; a bad one is off by one
    if (len >= 8) begin
      acc = '0;
      for (int i = 0; i < nw; i++) acc = oc_add16(acc, words[i]);
      words[0][47:32] = ~acc ^ (bad_ck ? 16'h0001 : 16'h0000);
    end
    for (int i = 0; i < nw; i++) begin
      nb = (i == nw - 1) ? len - 8 * i : 8;
      b.word = words[i] | ({$urandom, $urandom} & ~keep_bytes(nb));
      b.fin  = (i == nw - 1) && !empty_tail;
      b.nbv  = b.fin ? 4'(nb) : 4'($urandom_range(0, 15));
      if (b.fin && nb == 8 && wide_bv) b.nbv = 4'($urandom_range(9, 15));
      b.peer = $urandom;
      msg_beats.push_back(b);
    end
    // lone closing beat that carries no bytes
    if (nw == 0 || empty_tail) begin
      b = '{{$urandom, $urandom}, 4'h0, 1'b1, $urandom};
      msg_beats.push_back(b);
    end
  endtask

  // pick one random message, mostly well-formed echo requests
  task automatic random_msg();
    int    pick;
    int    len;
    int    nw;
    beat_t b;
    logic [7:0] typ;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 19) == 0)
        len = ($urandom_range(0, 4) == 0) ? BUF_WORDS * 8 : $urandom_range(65, BUF_WORDS * 8);
      else
        len = $urandom_range(8, 64);
      build_msg(len, TYPE_ECHO_REQ, 8'($urandom), $urandom, FILL_RAND, 1'b0,
                $urandom_range(0, 3) == 0, ($urandom_range(0, 4) == 0) && (len % 8 == 0));
    end else if (pick < 78) begin
      build_msg($urandom_range(8, 64), TYPE_ECHO_REQ, 8'($urandom), $urandom, FILL_RAND,
                1'b1, 1'b0, 1'b0);
    end else if (pick < 85) begin
      typ = 8'($urandom);
      if (typ == TYPE_ECHO_REQ) typ = 8'd13;
      build_msg($urandom_range(8, 40), typ, 8'($urandom), $urandom, FILL_RAND,
                $urandom_range(0, 3) == 0, 1'b0, 1'b0);
    end else if (pick < 91) begin
      build_msg($urandom_range(0, 7), TYPE_ECHO_REQ, 8'($urandom), $urandom, FILL_RAND,
                1'b0, 1'b0, 1'b0);
    end else if (pick < 96) begin
      // past the buffer; now and then long enough to saturate the byte count
      nw = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 130)
                                       : $urandom_range(BUF_WORDS + 1, BUF_WORDS + 16);
      build_msg(nw * 8 - $urandom_range(0, 7), TYPE_ECHO_REQ, 8'($urandom), $urandom,
                FILL_RAND, 1'b0, 1'b0, 1'b0);
    end else begin
      // noise: random words and counts
      msg_beats.delete();
      nw = $urandom_range(0, 5);
      for (int k = 0; k <= nw; k++) begin
        b = '{{$urandom, $urandom}, 4'($urandom_range(0, 15)), (k == nw), $urandom};
        msg_beats.push_back(b);
      end
    end
  endtask

  // drive the queued beats; each beat is accepted when start is high and busy low
  task automatic send_msg(input bit idle_ok, input bit typed, input status_t typed_st);
    beat_t  b;
    reply_t r;
    while (msg_beats.size() > 0) begin
      b = msg_beats.pop_front();
      if (idle_ok && $urandom_range(0, 3) == 0) begin
        start    <= 1'b0;
        msg_word <= {$urandom, $urandom};
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      start       <= 1'b1;
      msg_word    <= b.word;
      bytes_valid <= b.nbv;
      last_word   <= b.fin;
      peer_addr   <= b.peer;
      @(posedge clk);
      while (busy) @(posedge clk);
      beats_sent++;
      predict_reply(b);
      if (b.fin && typed) begin
        r = '{64'h0, 4'h0, 1'b1, typed_st, addr_cfg, peer_hold};
        reply_q.push_back(r);
      end else begin
        foreach (msg_replies[k]) reply_q.push_back(msg_replies[k]);
      end
    end
  endtask

  // register write once the block has drained
  task automatic set_local_addr(input logic [31:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    local_addr_we    <= 1'b1;
    local_addr_wdata <= v;
    @(posedge clk);
    addr_cfg = v;
    local_addr_we <= 1'b0;
  endtask

  task automatic flag_error(input string what, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("ERROR %s: exp w=%h b=%0d l=%0b s=%0d src=%h dst=%h", what, want.word,
             want.nbytes, want.fin, want.st, want.src, want.dst);
      $display(" got w=%h b=%0d l=%0b s=%0d src=%h dst=%h", got.word, got.nbytes, got.fin,
               got.st, got.src, got.dst);
    end
  endtask

  // result beats against the oldest expectation
  always @(posedge clk) begin : mon
    reply_t got;
    reply_t want;
    if (!rst && reply_valid) begin
      got = '{reply_word, reply_bytes, reply_last, status_t'(status),
              reply_src_addr, reply_dst_addr};
      if (reply_q.size() == 0) begin
        flag_error("unexpected reply", '0, got);
      end else begin
        want = reply_q.pop_front();
        if (got !== want) flag_error("reply mismatch", want, got);
      end
    end
  end

  initial begin : stim
    dir_row_t row;
    int       target;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed messages
    set_local_addr(32'hFFFF_FFFF);
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      build_msg(row.len, row.typ, row.code, row.idseq, row.fill, row.bad_ck, row.wide_bv,
                row.empty_tail);
      send_msg(1'b1, row.typed, row.st);
    end

    // random phases, each with its own address; the last runs without gaps
    for (int ph = 0; ph < 4; ph++) begin
      set_local_addr((ph == 0) ? 32'h0000_0000 : $urandom);
      target = beats_sent + RAND_BEATS / 4;
      while (beats_sent < target) begin
        random_msg();
        send_msg(ph != 3, 1'b0, ST_OK);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS icmp_echo_responder");
    end else begin
      $display("FAIL icmp_echo_responder");
    end
    $finish;
  end

endmodule

/* icmp_echo_responder.f */
+incdir+rtl
rtl/icmp_pkg.sv
rtl/icmp_job_q.sv
rtl/icmp_front.sv
rtl/icmp_back.sv
rtl/icmp_echo_responder.sv
tb/sv/tb.sv
